FILE: rtl/tccw_pkg.sv
// shared types and constants of the text console character writer
`default_nettype none

package tccw_pkg;

	localparam int KIND_W   = 3;
	localparam int CHAR_W   = 8;
	localparam int POS_W    = 11;
	localparam int ATTR_W   = 8;
	localparam int CURSOR_W = 11;
	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;
	localparam int CELL_W   = CHAR_W + ATTR_W;

	localparam logic [KIND_W-1:0] KIND_PUT   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SETC  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WCHAR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_WATTR = 3'd4;

	localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
	localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
	localparam logic [ATTR_W-1:0] PLAIN_ATTR = 8'h07;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_RMW   = 8'b0000_0100,
		ST_DIV   = 8'b0000_1000,
		ST_CHECK = 8'b0001_0000,
		ST_COPY  = 8'b0010_0000,
		ST_BLANK = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/tccw_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/text_console_char_writer.sv
// text console cell store with linear cursor, put char, scroll and direct cell access
//
//  channel | direction | transfer when          | payload
//  in      | input     | in_valid && !in_stall  | kind, char_code, position, attrib_value
//  out     | output    | out_valid && !out_stall| cursor_now, cursor_row, cursor_col,
//          |           |                        | cell_char, cell_attrib, did_scroll, range_error
//
// plain put char, newline, backspace: check, done; read and write cell: rmw, done
// range errors, unused kinds: done; set cursor: one division, tab: two; then check, done
// two multiplier passes per division; a scroll moves rows up over the single port pair,
// then blanks the last row; after reset the ram is cleared while in_stall stays high
// one item at a time; the last state waits while an earlier result is still stalled at the output
`default_nettype none

module text_console_char_writer #(
	parameter int COLS     = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STEP = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [tccw_pkg::KIND_W-1:0]     kind,
	input  wire logic [tccw_pkg::CHAR_W-1:0]     char_code,
	input  wire logic [tccw_pkg::POS_W-1:0]      position,
	input  wire logic [tccw_pkg::ATTR_W-1:0]     attrib_value,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [tccw_pkg::CURSOR_W-1:0]   cursor_now,
	output logic      [tccw_pkg::ROW_W-1:0]      cursor_row,
	output logic      [tccw_pkg::COL_W-1:0]      cursor_col,
	output logic      [tccw_pkg::CHAR_W-1:0]     cell_char,
	output logic      [tccw_pkg::ATTR_W-1:0]     cell_attrib,
	output logic                                 did_scroll,
	output logic                                 range_error
);

	localparam int CELLS          = COLS * ROWS;
	localparam int LAST_ROW_START = (ROWS - 1) * COLS;
	localparam int MAXD           = (COLS > TAB_STEP) ? COLS : TAB_STEP;
	localparam int CW             = $clog2(CELLS + MAXD + 1);
	localparam int AW             = $clog2(CELLS);
	localparam int RW             = $clog2(ROWS + 1);
	localparam int KW             = $clog2(COLS);
	localparam int XW             = (CW > tccw_pkg::POS_W) ? CW : tccw_pkg::POS_W;
	localparam int TAB_SH         = CW + $clog2(TAB_STEP);
	localparam int COL_SH         = CW + $clog2(COLS);
	localparam int TAB_MUL        = ((1 << TAB_SH) + TAB_STEP - 1) / TAB_STEP;
	localparam int COL_MUL        = ((1 << COL_SH) + COLS - 1) / COLS;
	localparam int MW             = CW + 1;
	localparam int PW             = CW + MW;

	tccw_pkg::state_t state_q;

	logic [CW-1:0]                   cursor_q;
	logic [RW-1:0]                   row_q;
	logic [KW-1:0]                   col_q;
	logic [tccw_pkg::KIND_W-1:0]     kind_q;
	logic [tccw_pkg::CHAR_W-1:0]     ch_q;
	logic [tccw_pkg::ATTR_W-1:0]     attr_q;
	logic [AW-1:0]                   pos_addr_q;
	logic [tccw_pkg::CHAR_W-1:0]     res_char_q;
	logic [tccw_pkg::ATTR_W-1:0]     res_attr_q;
	logic                            scroll_q;
	logic                            err_q;

	logic [CW-1:0]                   div_dvd_q;
	logic [CW-1:0]                   div_quo_q;
	logic                            div_ph_q;
	logic                            div_tab_q;

	logic [AW-1:0]                   clr_cnt_q;
	logic [AW-1:0]                   scr_cnt_q;

	logic                            wr_pend_s1;
	logic [AW-1:0]                   wr_addr_s1;
	logic                            wr_blank_s1;

	logic                            out_valid_q;
	logic [tccw_pkg::CURSOR_W-1:0]   out_cursor_q;
	logic [tccw_pkg::ROW_W-1:0]      out_row_q;
	logic [tccw_pkg::COL_W-1:0]      out_col_q;
	logic [tccw_pkg::CHAR_W-1:0]     out_char_q;
	logic [tccw_pkg::ATTR_W-1:0]     out_attr_q;
	logic                            out_scroll_q;
	logic                            out_err_q;

	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [tccw_pkg::CELL_W-1:0]     ram_wdata;
	logic [AW-1:0]                   ram_raddr;
	logic [tccw_pkg::CELL_W-1:0]     ram_rdata;

	logic                            accept;
	logic                            is_nl;
	logic                            is_bs;
	logic                            is_tab;
	logic                            pos_ok;
	logic                            cur_at0;
	logic                            put_wr;
	logic                            res_load;

	logic [CW-1:0]                   mul_a;
	logic [MW-1:0]                   mul_b;
	logic [PW-1:0]                   mul_p;
	logic [CW-1:0]                   quo_nx;
	logic [CW-1:0]                   rem_nx;
	logic [CW-1:0]                   tab_next;

	tccw_ram #(
		.WIDTH(tccw_pkg::CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign accept  = in_valid && (state_q == tccw_pkg::ST_IDLE);
	assign in_stall = (state_q != tccw_pkg::ST_IDLE);
	assign is_nl   = (char_code == tccw_pkg::CH_LF) || (char_code == tccw_pkg::CH_CR);
	assign is_bs   = (char_code == tccw_pkg::CH_BS);
	assign is_tab  = (char_code == tccw_pkg::CH_TAB);
	assign pos_ok  = XW'(position) < XW'(CELLS);
	assign cur_at0 = (cursor_q == '0);
	assign put_wr  = accept && (kind == tccw_pkg::KIND_PUT) && !is_nl && !is_tab
		&& (!is_bs || !cur_at0);
	assign res_load = (state_q == tccw_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	// shared multiplier: reciprocal quotient first, then quotient times divisor
	assign mul_a    = div_ph_q ? div_quo_q : div_dvd_q;
	assign mul_b    = div_ph_q ? (div_tab_q ? MW'(TAB_STEP) : MW'(COLS))
		: (div_tab_q ? MW'(TAB_MUL) : MW'(COL_MUL));
	assign mul_p    = PW'(mul_a) * PW'(mul_b);
	assign quo_nx   = div_tab_q ? CW'(mul_p >> TAB_SH) : CW'(mul_p >> COL_SH);
	assign rem_nx   = div_dvd_q - CW'(mul_p);
	assign tab_next = cursor_q + CW'(TAB_STEP) - rem_nx;

	assign ram_raddr = ((state_q == tccw_pkg::ST_COPY) || (state_q == tccw_pkg::ST_BLANK))
		? scr_cnt_q : AW'(position);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		if (state_q == tccw_pkg::ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
		end else if (wr_pend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = wr_blank_s1 ? {ram_rdata[15:8], tccw_pkg::SPACE_CODE} : ram_rdata;
		end else if (state_q == tccw_pkg::ST_RMW) begin
			ram_waddr = pos_addr_q;
			if (kind_q == tccw_pkg::KIND_WCHAR) begin
				ram_we    = 1'b1;
				ram_wdata = {ram_rdata[15:8], ch_q};
			end else if (kind_q == tccw_pkg::KIND_WATTR) begin
				ram_we    = 1'b1;
				ram_wdata = {attr_q, ram_rdata[7:0]};
			end
		end else if (put_wr) begin
			ram_we    = 1'b1;
			ram_waddr = is_bs ? AW'(cursor_q - CW'(1)) : AW'(cursor_q);
			ram_wdata = {tccw_pkg::PLAIN_ATTR, is_bs ? tccw_pkg::SPACE_CODE : char_code};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tccw_pkg::ST_CLEAR;
			cursor_q     <= '0;
			row_q        <= '0;
			col_q        <= '0;
			kind_q       <= '0;
			ch_q         <= '0;
			attr_q       <= '0;
			pos_addr_q   <= '0;
			res_char_q   <= '0;
			res_attr_q   <= '0;
			scroll_q     <= 1'b0;
			err_q        <= 1'b0;
			div_dvd_q    <= '0;
			div_quo_q    <= '0;
			div_ph_q     <= 1'b0;
			div_tab_q    <= 1'b0;
			clr_cnt_q    <= '0;
			scr_cnt_q    <= '0;
			wr_pend_s1   <= 1'b0;
			wr_addr_s1   <= '0;
			wr_blank_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_cursor_q <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			out_char_q   <= '0;
			out_attr_q   <= '0;
			out_scroll_q <= 1'b0;
			out_err_q    <= 1'b0;
		end else begin
			wr_pend_s1 <= (state_q == tccw_pkg::ST_COPY) || (state_q == tccw_pkg::ST_BLANK);
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				tccw_pkg::ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(CELLS - 1)) begin
						state_q <= tccw_pkg::ST_IDLE;
					end
				end
				tccw_pkg::ST_IDLE: begin
					if (accept) begin
						kind_q     <= kind;
						ch_q       <= char_code;
						attr_q     <= attrib_value;
						pos_addr_q <= AW'(position);
						res_char_q <= '0;
						res_attr_q <= '0;
						scroll_q   <= 1'b0;
						err_q      <= 1'b0;
						case (kind)
							tccw_pkg::KIND_PUT: begin
								state_q <= tccw_pkg::ST_CHECK;
								if (is_nl) begin
									cursor_q <= cursor_q + CW'(COLS) - CW'(col_q);
									col_q    <= '0;
									row_q    <= row_q + RW'(1);
								end else if (is_bs) begin
									if (!cur_at0) begin
										cursor_q <= cursor_q - CW'(1);
										if (col_q == '0) begin
											col_q <= KW'(COLS - 1);
											row_q <= row_q - RW'(1);
										end else begin
											col_q <= col_q - KW'(1);
										end
									end
								end else if (is_tab) begin
									div_dvd_q <= cursor_q + CW'(1);
									div_ph_q  <= 1'b0;
									div_tab_q <= 1'b1;
									state_q   <= tccw_pkg::ST_DIV;
								end else begin
									cursor_q <= cursor_q + CW'(1);
									if (col_q == KW'(COLS - 1)) begin
										col_q <= '0;
										row_q <= row_q + RW'(1);
									end else begin
										col_q <= col_q + KW'(1);
									end
								end
							end
							tccw_pkg::KIND_SETC: begin
								if (pos_ok) begin
									cursor_q  <= CW'(position);
									div_dvd_q <= CW'(position);
									div_ph_q  <= 1'b0;
									div_tab_q <= 1'b0;
									state_q   <= tccw_pkg::ST_DIV;
								end else begin
									err_q   <= 1'b1;
									state_q <= tccw_pkg::ST_DONE;
								end
							end
							tccw_pkg::KIND_READ,
							tccw_pkg::KIND_WCHAR,
							tccw_pkg::KIND_WATTR: begin
								if (pos_ok) begin
									state_q <= tccw_pkg::ST_RMW;
								end else begin
									err_q   <= 1'b1;
									state_q <= tccw_pkg::ST_DONE;
								end
							end
							default: begin
								state_q <= tccw_pkg::ST_DONE;
							end
						endcase
					end
				end
				tccw_pkg::ST_RMW: begin
					if (kind_q == tccw_pkg::KIND_READ) begin
						res_char_q <= ram_rdata[7:0];
						res_attr_q <= ram_rdata[15:8];
					end
					state_q <= tccw_pkg::ST_DONE;
				end
				tccw_pkg::ST_DIV: begin
					if (!div_ph_q) begin
						div_quo_q <= quo_nx;
						div_ph_q  <= 1'b1;
					end else begin
						div_ph_q <= 1'b0;
						if (div_tab_q) begin
							// remainder of cursor+1 by the tab step gives the advance
							cursor_q  <= tab_next;
							div_dvd_q <= tab_next;
							div_tab_q <= 1'b0;
						end else begin
							row_q   <= RW'(div_quo_q);
							col_q   <= KW'(rem_nx);
							state_q <= tccw_pkg::ST_CHECK;
						end
					end
				end
				tccw_pkg::ST_CHECK: begin
					if (cursor_q >= CW'(CELLS)) begin
						cursor_q  <= CW'(LAST_ROW_START);
						row_q     <= RW'(ROWS - 1);
						col_q     <= '0;
						scroll_q  <= 1'b1;
						scr_cnt_q <= AW'(COLS);
						state_q   <= tccw_pkg::ST_COPY;
					end else begin
						state_q <= tccw_pkg::ST_DONE;
					end
				end
				tccw_pkg::ST_COPY: begin
					// read one row down, write it back one row up in the next cycle
					wr_addr_s1  <= scr_cnt_q - AW'(COLS);
					wr_blank_s1 <= 1'b0;
					if (scr_cnt_q == AW'(CELLS - 1)) begin
						scr_cnt_q <= AW'(LAST_ROW_START);
						state_q   <= tccw_pkg::ST_BLANK;
					end else begin
						scr_cnt_q <= scr_cnt_q + AW'(1);
					end
				end
				tccw_pkg::ST_BLANK: begin
					wr_addr_s1  <= scr_cnt_q;
					wr_blank_s1 <= 1'b1;
					if (scr_cnt_q == AW'(CELLS - 1)) begin
						state_q <= tccw_pkg::ST_DONE;
					end else begin
						scr_cnt_q <= scr_cnt_q + AW'(1);
					end
				end
				tccw_pkg::ST_DONE: begin
					if (res_load) begin
						out_cursor_q <= tccw_pkg::CURSOR_W'(cursor_q);
						out_row_q    <= tccw_pkg::ROW_W'(row_q);
						out_col_q    <= tccw_pkg::COL_W'(col_q);
						out_char_q   <= res_char_q;
						out_attr_q   <= res_attr_q;
						out_scroll_q <= scroll_q;
						out_err_q    <= err_q;
						state_q      <= tccw_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tccw_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign cursor_now  = out_cursor_q;
	assign cursor_row  = out_row_q;
	assign cursor_col  = out_col_q;
	assign cell_char   = out_char_q;
	assign cell_attrib = out_attr_q;
	assign did_scroll  = out_scroll_q;
	assign range_error = out_err_q;

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second transfer accepted while an item is in work");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tccw_pkg::ST_IDLE) |-> (cursor_q < CW'(CELLS)))
		else $error("cursor beyond the screen while idle");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && did_scroll) |->
		(cursor_now == tccw_pkg::CURSOR_W'(LAST_ROW_START)) && (cursor_col == '0))
		else $error("scroll result without cursor at last row start");

	a_scroll_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_s1 |-> ((state_q == tccw_pkg::ST_COPY) || (state_q == tccw_pkg::ST_BLANK)
		|| (state_q == tccw_pkg::ST_DONE)))
		else $error("scroll write pending outside a scroll");
`endif

endmodule

`default_nettype wire
